[design/pli_pkg.sv]
// shared types and constants for the positional list block
package pli_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ELEM_W_DEF   = 32;

  localparam int REQ_W      = 2;
  localparam int POS_W      = 5;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int ELEM_OUT_W = 32;
  localparam int INDEX_W    = 4;
  localparam int COUNT_W    = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_LIST = 2'd0,
    REQ_INS  = 2'd1,
    REQ_DEL  = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_t;

  // controller to datapath
  typedef struct packed {
    logic     req_load;
    cell_op_t op;
    logic     out_load;
    status_t  status;
    logic     last;
    logic     elem_sel;
    logic     idx_clr;
    logic     idx_inc;
  } pli_cmd_t;

  // datapath to controller
  typedef struct packed {
    req_t req_type;
    logic full;
    logic empty;
    logic ins_ok;
    logic del_ok;
    logic idx_last;
    logic out_valid;
  } pli_stat_t;

endpackage

[design/pli_dpath.sv]
// datapath: request register, shifting cell chain, count, list index and output register
module pli_dpath #(
  parameter int CAPACITY      = pli_pkg::CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = pli_pkg::ELEM_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pli_pkg::pli_cmd_t             cmd,
  output pli_pkg::pli_stat_t            stat,
  input  logic [pli_pkg::REQ_W-1:0]     in_req_type,
  input  logic [pli_pkg::POS_W-1:0]     in_position,
  input  logic [pli_pkg::VAL_W-1:0]     in_value,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [pli_pkg::STATUS_W-1:0]  out_status,
  output logic [pli_pkg::ELEM_OUT_W-1:0] out_element,
  output logic [pli_pkg::INDEX_W-1:0]   out_index,
  output logic                          out_last,
  output logic [pli_pkg::COUNT_W-1:0]   out_count
);
  import pli_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  req_t                     req_type_r;
  logic [POS_W-1:0]         req_pos_r;
  logic [ELEMENT_WIDTH-1:0] req_val_r;

  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] idx_r;

  logic [ELEMENT_WIDTH-1:0] cells_r   [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] cells_nxt [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] up_w      [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] dn_w      [CAPACITY];

  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [ELEM_OUT_W-1:0]  out_element_r;
  logic [INDEX_W-1:0]     out_index_r;
  logic                   out_last_r;
  logic [COUNT_W-1:0]     out_count_r;

  logic [CMPW-1:0] pos_ext, occ_ext;

  assign pos_ext = CMPW'(req_pos_r);
  assign occ_ext = CMPW'(occ_r);

  // neighbor taps of each cell
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g == CAPACITY - 1) begin : g_top
      assign up_w[g] = cells_r[g];
    end else begin : g_mid
      assign up_w[g] = cells_r[g+1];
    end
    if (g == 0) begin : g_bot
      assign dn_w[g] = cells_r[g];
    end else begin : g_low
      assign dn_w[g] = cells_r[g-1];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      case (cmd.op)
        OP_INS: begin
          if (CMPW'(i) > pos_ext) cells_nxt[i] = dn_w[i];
          else if (CMPW'(i) == pos_ext) cells_nxt[i] = req_val_r;
        end
        OP_DEL: begin
          if (CMPW'(i) >= pos_ext) cells_nxt[i] = up_w[i];
        end
        OP_ROT: begin
          // rotate occupied entries down by one, entry 0 wraps to the top
          if (CMPW'(i) + CMPW'(1) == occ_ext) cells_nxt[i] = cells_r[0];
          else if (CMPW'(i) < occ_ext) cells_nxt[i] = up_w[i];
        end
        default: cells_nxt[i] = cells_r[i];
      endcase
    end
  end

  always_comb begin
    case (cmd.op)
      OP_INS:  occ_nxt = occ_r + CW'(1);
      OP_DEL:  occ_nxt = occ_r - CW'(1);
      default: occ_nxt = occ_r;
    endcase
  end

  always_comb begin
    stat.req_type  = req_type_r;
    stat.full      = (occ_r == CW'(CAPACITY));
    stat.empty     = (occ_r == '0);
    stat.ins_ok    = (pos_ext <= occ_ext);
    stat.del_ok    = (pos_ext < occ_ext);
    stat.idx_last  = (({1'b0, idx_r} + (CW+1)'(1)) == {1'b0, occ_r});
    stat.out_valid = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_type_r <= req_t'(in_req_type);
      req_pos_r  <= in_position;
      req_val_r  <= ELEMENT_WIDTH'(in_value);
    end
    if (cmd.out_load) begin
      out_status_r  <= cmd.status;
      out_element_r <= cmd.elem_sel ? ELEM_OUT_W'(cells_r[0]) : '0;
      out_index_r   <= cmd.elem_sel ? INDEX_W'(idx_r) : '0;
      out_last_r    <= cmd.last;
      out_count_r   <= COUNT_W'(occ_nxt);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_index   = out_index_r;
  assign out_last    = out_last_r;
  assign out_count   = out_count_r;

endmodule

[design/pli_ctrl.sv]
// controller: request sequencing, error checks and list streaming
module pli_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_stall,
  input  pli_pkg::pli_stat_t stat,
  output pli_pkg::pli_cmd_t  cmd
);
  import pli_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  state_t state_r, state_nxt;
  logic   out_free;
  logic   done;

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_HOLD;
    cmd.status   = ST_OK;
    done         = 1'b0;
    out_free     = !stat.out_valid || !out_stall;

    if (state_r != S_IDLE && out_free) begin
      cmd.out_load = 1'b1;
      cmd.last     = 1'b1;
      case (stat.req_type)
        REQ_LIST: begin
          if (stat.empty) begin
            cmd.status = ST_EMPTY;
            done       = 1'b1;
          end else begin
            cmd.elem_sel = 1'b1;
            cmd.op       = OP_ROT;
            cmd.last     = stat.idx_last;
            if (stat.idx_last) begin
              done = 1'b1;
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
        end
        REQ_INS: begin
          done = 1'b1;
          if (stat.full) begin
            cmd.status = ST_FULL;
          end else if (!stat.ins_ok) begin
            cmd.status = ST_RANGE;
          end else begin
            cmd.op = OP_INS;
          end
        end
        REQ_DEL: begin
          done = 1'b1;
          if (stat.empty) begin
            cmd.status = ST_EMPTY;
          end else if (!stat.del_ok) begin
            cmd.status = ST_RANGE;
          end else begin
            cmd.op = OP_DEL;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end

    cmd.idx_clr  = done;
    in_stall     = !(state_r == S_IDLE || done);
    cmd.req_load = in_valid && !in_stall;

    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.req_load) state_nxt = S_EXEC;
      end
      S_EXEC, S_LIST: begin
        if (done) begin
          state_nxt = cmd.req_load ? S_EXEC : S_IDLE;
        end else if (cmd.out_load) begin
          state_nxt = S_LIST;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/positional_list_insert_delete_top.sv]
// top level of the positional list block: controller plus datapath
//
// keeps an ordered list of up to CAPACITY words and serves list, insert
// and delete requests that arrive on the in_ channel
// in_ channel: one transfer per request (type, position, value)
// out_ channel: one transfer per result (status, element, index, last, count)
// insert, delete and unused request types give exactly one result;
// a list request gives one result per occupied entry, or one empty
// result, with last set on the final one
// a request is captured in the request register, and its result then
// in the output register
// throughput: one insert or delete per cycle unless the receiver stalls;
// a list request holds the input side until its last result, as it
// streams entry 0 of the cell chain and rotates the occupied entries
// once per result; insert and delete shift the chain from the position up
// reset empties the list and drops any pending request or result
// when the receiver stalls, the output register holds its result and the
// request register takes at most one more request before in_stall rises
module positional_list_insert_delete_top #(
  parameter int CAPACITY      = pli_pkg::CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = pli_pkg::ELEM_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pli_pkg::REQ_W-1:0]      in_req_type,
  input  logic [pli_pkg::POS_W-1:0]      in_position,
  input  logic [pli_pkg::VAL_W-1:0]      in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pli_pkg::STATUS_W-1:0]   out_status,
  output logic [pli_pkg::ELEM_OUT_W-1:0] out_element,
  output logic [pli_pkg::INDEX_W-1:0]    out_index,
  output logic                           out_last,
  output logic [pli_pkg::COUNT_W-1:0]    out_count
);
  import pli_pkg::*;

  // command and status between controller and datapath
  pli_cmd_t  cmd;
  pli_stat_t stat;

  // sequencing: request acceptance, error checks, list streaming
  pli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage: request register, cell chain, count and output register
  pli_dpath #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_req_type (in_req_type),
    .in_position (in_position),
    .in_value    (in_value),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_element (out_element),
    .out_index   (out_index),
    .out_last    (out_last),
    .out_count   (out_count)
  );

endmodule
